@@ rtl/ssce_pkg.sv @@
// Shared types and constants for the sphere set containment engine.
// Used by the engine top level and its checker; no dependencies.
package ssce_pkg;

   // Default number of spheres the store can hold.
   localparam int CAPACITY_DEF = 256;

   // Field widths.
   localparam int POS_W = 20;
   localparam int RAD_W = 16;
   localparam int VAL_W = 17;
   localparam int IDX_OUT_W = 8;
   localparam int CNT_OUT_W = 9;

   // Wide internal widths: squared distance, fraction quotient.
   localparam int DSQ_W = 42;
   localparam int FRAC_W = 32;

   // Packed store entry: x, y, z, radius.
   localparam int ENTRY_W = 3 * POS_W + RAD_W;

   // Register map.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_MIN_RADIUS = 1'b0;
   localparam logic [RAD_W-1:0] MIN_RADIUS_RESET = 16'd256;

   // Full containment answer, 1.0 in Q16.16.
   localparam logic [FRAC_W-1:0] FULL_CONTAIN = 32'd65536;

   typedef enum logic [1:0] {
      OP_CLEAR     = 2'd0,
      OP_ADD       = 2'd1,
      OP_CONTAIN   = 2'd2,
      OP_INTERSECT = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_START,
      ST_READ,
      ST_LOAD,
      ST_MUL_X,
      ST_MUL_Y,
      ST_MUL_Z,
      ST_MUL_C,
      ST_MUL_R,
      ST_SQRT,
      ST_EVAL,
      ST_DIV,
      ST_DIVEND,
      ST_NEXT,
      ST_DONE
   } state_type;

endpackage

@@ rtl/sphere_set_containment_engine_top.sv @@
// Top level of the sphere set containment engine: sequencer and shared datapath.
// Depends on ssce_pkg and on the ssce_ram sphere store.

// The engine takes one transaction at a time and stalls its request channel until the
// result is registered. A query walks the stored spheres in order; each visited sphere
// uses one shared 21x21 multiplier for the axis differences (and, for a containment
// query, for R-s and R), a square root that resolves one result bit per cycle and,
// for a containment query with partial overlap, a restoring divider that makes one
// quotient bit per cycle. The sphere store is a RAM with one read port, read one
// entry per sphere visited.
module sphere_set_containment_engine_top #(
   parameter int CAPACITY = ssce_pkg::CAPACITY_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_op,
   input  logic signed [ssce_pkg::POS_W-1:0] req_pos_x,
   input  logic signed [ssce_pkg::POS_W-1:0] req_pos_y,
   input  logic signed [ssce_pkg::POS_W-1:0] req_pos_z,
   input  logic [ssce_pkg::RAD_W-1:0]      req_radius,
   input  logic                            req_mark_priority,
   // Response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ssce_pkg::VAL_W-1:0]      rsp_value,
   output logic [ssce_pkg::IDX_OUT_W-1:0]  rsp_best_index,
   output logic                            rsp_found,
   output logic [ssce_pkg::CNT_OUT_W-1:0]  rsp_sphere_count,
   output logic                            rsp_has_priority,
   output logic                            rsp_overflow,
   // Register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ssce_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ssce_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ssce_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = ssce_pkg::POS_W;
   localparam int RW = ssce_pkg::RAD_W;
   localparam int DW = ssce_pkg::DSQ_W;
   localparam int FW = ssce_pkg::FRAC_W;
   localparam int MW = PW + 1;

   // ---------------- Registers ----------------
   ssce_pkg::state_type state_ff, state_in;
   ssce_pkg::op_type    op_ff;
   logic signed [PW-1:0] px_ff, py_ff, pz_ff;
   logic [RW-1:0]        s_ff;
   logic                 mark_ff;
   logic [RW-1:0]        min_r_ff;
   logic [CW-1:0]        count_ff, count_in;
   logic                 prio_ff, prio_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [DW-1:0]        acc_ff, acc_in;
   logic [DW-1:0]        sq_v_ff, sq_v_in, sq_r_ff, sq_r_in, sq_bit_ff, sq_bit_in;
   logic [FW-1:0]        dq_ff, dq_in;
   logic [RW:0]          rem_ff, rem_in;
   logic [4:0]           div_cnt_ff, div_cnt_in;
   logic [FW-1:0]        best_val_ff, best_val_in;
   logic [CW-1:0]        best_idx_ff, best_idx_in;
   logic                 found_ff, found_in;
   logic                 ovf_ff, ovf_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ssce_pkg::VAL_W-1:0]     rsp_value_ff;
   logic [ssce_pkg::IDX_OUT_W-1:0] rsp_best_ff;
   logic                           rsp_found_ff, rsp_ovf_ff, rsp_prio_ff;
   logic [ssce_pkg::CNT_OUT_W-1:0] rsp_count_ff;

   // ---------------- Sphere store ----------------
   logic                          wr_en;
   logic [ssce_pkg::ENTRY_W-1:0]  rd_data;
   logic signed [PW-1:0]          st_x, st_y, st_z;
   logic [RW-1:0]                 st_r;

   ssce_ram #(
      .WIDTH(ssce_pkg::ENTRY_W),
      .DEPTH(CAPACITY)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[AW-1:0]),
      .wr_data({px_ff, py_ff, pz_ff, s_ff}),
      .rd_addr(idx_ff[AW-1:0]),
      .rd_data(rd_data)
   );

   assign {st_x, st_y, st_z, st_r} = rd_data;

   // ---------------- Register port ----------------
   logic csr_wr;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == ssce_pkg::REG_MIN_RADIUS);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == ssce_pkg::REG_MIN_RADIUS)
                       ? {{(ssce_pkg::CSR_DATA_W - RW){1'b0}}, min_r_ff}
                       : '0;

   // ---------------- Shared multiplier ----------------
   // One operand pair per cycle: axis differences, then R-s, then R.
   logic signed [MW-1:0] diff;
   logic [MW-1:0]        mag, mul_op;
   logic [DW-1:0]        prod;
   logic [RW-1:0]        r_minus_s;

   assign r_minus_s = st_r - s_ff;

   always_comb begin
      case (state_ff)
         ssce_pkg::ST_MUL_Y: diff = MW'(st_y) - MW'(py_ff);
         ssce_pkg::ST_MUL_Z: diff = MW'(st_z) - MW'(pz_ff);
         default:            diff = MW'(st_x) - MW'(px_ff);
      endcase
   end

   assign mag = diff[MW-1] ? MW'(-diff) : MW'(diff);

   always_comb begin
      case (state_ff)
         ssce_pkg::ST_MUL_C: mul_op = MW'(r_minus_s);
         ssce_pkg::ST_MUL_R: mul_op = MW'(st_r);
         default:            mul_op = mag;
      endcase
   end

   assign prod = DW'(mul_op * mul_op);

   // ---------------- Square root step ----------------
   logic [DW-1:0] sq_trial;
   logic          sq_take;
   assign sq_trial = sq_r_ff + sq_bit_ff;
   assign sq_take  = (sq_v_ff >= sq_trial);

   // ---------------- Divider step ----------------
   logic [RW+1:0] rem_shift;
   logic          div_take;
   assign rem_shift = {rem_ff, dq_ff[FW-1]};
   assign div_take  = (rem_shift >= (RW+2)'(s_ff));

   // Intersection depth candidate.
   logic [RW:0] tot;
   assign tot = (RW+1)'(st_r) + (RW+1)'(s_ff);

   // ---------------- Next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ssce_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (ssce_pkg::op_type'(req_op) inside
                           {ssce_pkg::OP_CLEAR, ssce_pkg::OP_ADD})
                          ? ssce_pkg::ST_UPDATE : ssce_pkg::ST_START;
            end
         end
         ssce_pkg::ST_UPDATE: state_in = ssce_pkg::ST_DONE;
         ssce_pkg::ST_START: begin
            state_in = (idx_ff < count_ff) ? ssce_pkg::ST_READ : ssce_pkg::ST_DONE;
         end
         ssce_pkg::ST_READ: state_in = ssce_pkg::ST_LOAD;
         ssce_pkg::ST_LOAD: begin
            if (st_r < min_r_ff || (op_ff == ssce_pkg::OP_CONTAIN && st_r < s_ff)) begin
               state_in = ssce_pkg::ST_DONE;
            end else begin
               state_in = ssce_pkg::ST_MUL_X;
            end
         end
         ssce_pkg::ST_MUL_X: state_in = ssce_pkg::ST_MUL_Y;
         ssce_pkg::ST_MUL_Y: state_in = ssce_pkg::ST_MUL_Z;
         ssce_pkg::ST_MUL_Z: begin
            state_in = (op_ff == ssce_pkg::OP_CONTAIN) ? ssce_pkg::ST_MUL_C
                                                       : ssce_pkg::ST_SQRT;
         end
         ssce_pkg::ST_MUL_C: begin
            state_in = (st_r > s_ff && acc_ff < prod) ? ssce_pkg::ST_DONE
                                                      : ssce_pkg::ST_MUL_R;
         end
         ssce_pkg::ST_MUL_R: begin
            state_in = (s_ff != '0 && acc_ff < prod) ? ssce_pkg::ST_SQRT
                                                      : ssce_pkg::ST_NEXT;
         end
         ssce_pkg::ST_SQRT: begin
            if (sq_bit_ff[0]) begin
               state_in = ssce_pkg::ST_EVAL;
            end
         end
         ssce_pkg::ST_EVAL: begin
            state_in = (op_ff == ssce_pkg::OP_CONTAIN) ? ssce_pkg::ST_DIV
                                                       : ssce_pkg::ST_NEXT;
         end
         ssce_pkg::ST_DIV: begin
            if (div_cnt_ff == '1) begin
               state_in = ssce_pkg::ST_DIVEND;
            end
         end
         ssce_pkg::ST_DIVEND: state_in = ssce_pkg::ST_NEXT;
         ssce_pkg::ST_NEXT:   state_in = ssce_pkg::ST_START;
         ssce_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ssce_pkg::ST_IDLE;
            end
         end
         default: state_in = ssce_pkg::ST_IDLE;
      endcase
   end

   // ---------------- Datapath and outputs ----------------
   always_comb begin
      wr_en        = 1'b0;
      count_in     = count_ff;
      prio_in      = prio_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      sq_v_in      = sq_v_ff;
      sq_r_in      = sq_r_ff;
      sq_bit_in    = sq_bit_ff;
      dq_in        = dq_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      best_val_in  = best_val_ff;
      best_idx_in  = best_idx_ff;
      found_in     = found_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ssce_pkg::ST_IDLE: begin
            idx_in      = '0;
            best_val_in = '0;
            best_idx_in = '0;
            found_in    = 1'b0;
            ovf_in      = 1'b0;
         end
         ssce_pkg::ST_UPDATE: begin
            if (op_ff == ssce_pkg::OP_CLEAR) begin
               count_in = '0;
               prio_in  = 1'b0;
            end else if (px_ff != '0 || py_ff != '0 || pz_ff != '0) begin
               if (count_ff >= CW'(CAPACITY)) begin
                  ovf_in = 1'b1;
               end else if (s_ff >= min_r_ff) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
                  prio_in  = prio_ff | mark_ff;
               end
            end
         end
         ssce_pkg::ST_MUL_X: acc_in = prod;
         ssce_pkg::ST_MUL_Y: acc_in = acc_ff + prod;
         ssce_pkg::ST_MUL_Z: begin
            acc_in    = acc_ff + prod;
            sq_v_in   = acc_ff + prod;
            sq_r_in   = '0;
            sq_bit_in = DW'(1) << (DW - 2);
         end
         ssce_pkg::ST_MUL_C: begin
            // Query sphere lies wholly inside this stored sphere.
            if (st_r > s_ff && acc_ff < prod) begin
               best_val_in = ssce_pkg::FULL_CONTAIN;
               best_idx_in = idx_ff;
               found_in    = 1'b1;
            end
         end
         ssce_pkg::ST_SQRT: begin
            if (sq_take) begin
               sq_v_in = sq_v_ff - sq_trial;
               sq_r_in = (sq_r_ff >> 1) + sq_bit_ff;
            end else begin
               sq_r_in = sq_r_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
         end
         ssce_pkg::ST_EVAL: begin
            if (op_ff == ssce_pkg::OP_CONTAIN) begin
               // Distance is below R here, so R - d fits the radius width.
               dq_in      = {st_r - sq_r_ff[RW-1:0], {(FW - RW){1'b0}}};
               rem_in     = '0;
               div_cnt_in = '0;
            end else if (DW'(tot) > sq_r_ff &&
                         FW'(DW'(tot) - sq_r_ff) > best_val_ff) begin
               best_val_in = FW'(DW'(tot) - sq_r_ff);
               best_idx_in = idx_ff;
               found_in    = 1'b1;
            end
         end
         ssce_pkg::ST_DIV: begin
            rem_in     = div_take ? (RW+1)'(rem_shift - (RW+2)'(s_ff))
                                  : (RW+1)'(rem_shift);
            dq_in      = {dq_ff[FW-2:0], div_take};
            div_cnt_in = div_cnt_ff + 1'b1;
         end
         ssce_pkg::ST_DIVEND: begin
            if (dq_ff > best_val_ff) begin
               best_val_in = dq_ff;
               best_idx_in = idx_ff;
               found_in    = 1'b1;
            end
         end
         ssce_pkg::ST_NEXT: idx_in = idx_ff + 1'b1;
         ssce_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign req_stall = (state_ff != ssce_pkg::ST_IDLE);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssce_pkg::ST_IDLE;
         count_ff     <= '0;
         prio_ff      <= 1'b0;
         min_r_ff     <= ssce_pkg::MIN_RADIUS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         prio_ff      <= prio_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr) begin
            min_r_ff <= csr_pwdata[RW-1:0];
         end
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      if (state_ff == ssce_pkg::ST_IDLE && req_valid) begin
         op_ff   <= ssce_pkg::op_type'(req_op);
         px_ff   <= req_pos_x;
         py_ff   <= req_pos_y;
         pz_ff   <= req_pos_z;
         s_ff    <= req_radius;
         mark_ff <= req_mark_priority;
      end
      idx_ff      <= idx_in;
      acc_ff      <= acc_in;
      sq_v_ff     <= sq_v_in;
      sq_r_ff     <= sq_r_in;
      sq_bit_ff   <= sq_bit_in;
      dq_ff       <= dq_in;
      rem_ff      <= rem_in;
      div_cnt_ff  <= div_cnt_in;
      best_val_ff <= best_val_in;
      best_idx_ff <= best_idx_in;
      found_ff    <= found_in;
      ovf_ff      <= ovf_in;
      // Result register loads as the transaction completes.
      if (state_ff == ssce_pkg::ST_DONE && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_value_ff <= best_val_ff[ssce_pkg::VAL_W-1:0];
         rsp_best_ff  <= found_ff ? ssce_pkg::IDX_OUT_W'(best_idx_ff) : '0;
         rsp_found_ff <= found_ff;
         rsp_count_ff <= ssce_pkg::CNT_OUT_W'(count_ff);
         rsp_prio_ff  <= prio_ff;
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_best_index   = rsp_best_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_sphere_count = rsp_count_ff;
   assign rsp_has_priority = rsp_prio_ff;
   assign rsp_overflow     = rsp_ovf_ff;

endmodule

@@ rtl/ssce_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// Holds the sphere store of the engine; no dependencies.
module ssce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and a registered read every cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/ssce_checker.sv @@
// Port-level checker for the sphere set containment engine, bound to the top level.
// Depends on ssce_pkg for field widths.
module ssce_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [ssce_pkg::VAL_W-1:0]     rsp_value,
   input logic [ssce_pkg::IDX_OUT_W-1:0] rsp_best_index,
   input logic                           rsp_found,
   input logic                           rsp_overflow
);

   // A stalled result transaction stays offered.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // Without a hit the index reads zero.
   a_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_best_index == '0)
      else $error("index set without a hit");

   // A dropped add carries no query answer.
   a_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> !rsp_found && rsp_value == '0)
      else $error("overflow with query answer");

   // No result in the first cycle after reset is released.
   a_rst: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind sphere_set_containment_engine_top ssce_checker u_ssce_checker (.*);
